// File: sv/ppit_pkg.sv
// Shared types and constants for the polygon point-inside test block.
// No dependencies; every other file in this folder refers to it.

package ppit_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 32;

    localparam int INDEX_W = 6;

    localparam int COUNT_W = 7;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    localparam int QUEUE_DEPTH = 2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_back_state;

    typedef struct packed {
        logic valid;
        logic last;
    } t_edge_ctl;

    typedef struct packed {
        logic valid;
        logic hit;
        logic last;
    } t_edge_res;

endpackage

// File: sv/ppit_front.sv
// Front end: accepts requests, drops out-of-range vertex writes, packs commands.
// Depends on ppit_pkg; feeds ppit_queue.

module ppit_front #(
    parameter int MAX_VERTICES = ppit_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = ppit_pkg::COORD_BITS_DEF,
    localparam int IDX_W = $clog2(MAX_VERTICES),
    localparam int CMD_W = 1 + IDX_W + 2 * COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [ppit_pkg::INDEX_W-1:0]  i_vertex_index,
    input  logic [COORD_BITS-1:0]         i_coord_x,
    input  logic [COORD_BITS-1:0]         i_coord_y,
    output logic                          o_push_valid,
    input  logic                          i_push_stall,
    output logic [CMD_W-1:0]              o_push_data
);

    logic             r_valid;
    logic             n_valid;
    logic [CMD_W-1:0] r_cmd;
    logic             accept;
    logic             keep;

    assign o_stall = r_valid && i_push_stall;
    assign accept  = i_valid && !o_stall;
    assign keep    = (i_func == ppit_pkg::FUNC_QUERY) || (int'(i_vertex_index) < MAX_VERTICES);

    always_comb begin
        if (accept) begin
            n_valid = keep;
        end else begin
            n_valid = r_valid && i_push_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= {i_func, IDX_W'(i_vertex_index), i_coord_x, i_coord_y};
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = r_cmd;

endmodule

// File: sv/ppit_queue.sv
// Short command queue between the front end and the back end.
// Depends on ppit_pkg for its depth.

module ppit_queue #(
    parameter int W = 8,
    localparam int DEPTH = ppit_pkg::QUEUE_DEPTH,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [W-1:0] o_data
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_stall = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: sv/ppit_edge.sv
// Edge crossing pipeline: straddle test and exact cross-product compare.
// Depends on ppit_pkg for the control and result structs.

module ppit_edge #(
    parameter int COORD_BITS = ppit_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppit_pkg::t_edge_ctl          i_ctl,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output ppit_pkg::t_edge_res          o_res
);

    localparam int D = COORD_BITS + 1;
    localparam int L = D / 2;
    localparam int H = D - L;
    localparam int P = 2 * D;

    ppit_pkg::t_edge_ctl r1_ctl, r2_ctl, r3_ctl;
    logic [1:0] r1_flg, r2_flg, r3_flg;

    logic signed [D-1:0] r1_d1, r1_dy, r1_d2, r1_dx;
    logic signed [D+L:0]   r2_l_lo, r2_r_lo;
    logic signed [D+H-1:0] r2_l_hi, r2_r_hi;
    logic signed [P-1:0] r3_l, r3_r;

    logic up, down;
    logic n_hit;

    assign up   = (i_ay <= i_py) && (i_by > i_py);
    assign down = (i_ay > i_py) && (i_by <= i_py);

    always_comb begin
        if (r3_flg[0]) begin
            n_hit = r3_flg[1] && (r3_l >= r3_r);
        end else begin
            n_hit = r3_flg[1] && (r3_l <= r3_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            o_res  <= '0;
        end else begin
            r1_ctl      <= i_ctl;
            r2_ctl      <= r1_ctl;
            r3_ctl      <= r2_ctl;
            o_res.valid <= r3_ctl.valid;
            o_res.hit   <= n_hit;
            o_res.last  <= r3_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_flg  <= {up || down, up};
        r1_d1   <= D'(i_ax) - D'(i_px);
        r1_dy   <= D'(i_by) - D'(i_ay);
        r1_d2   <= D'(i_ay) - D'(i_py);
        r1_dx   <= D'(i_bx) - D'(i_ax);

        r2_flg  <= r1_flg;
        r2_l_lo <= r1_d1 * $signed({1'b0, r1_dy[L-1:0]});
        r2_l_hi <= r1_d1 * $signed(r1_dy[D-1:L]);
        r2_r_lo <= r1_d2 * $signed({1'b0, r1_dx[L-1:0]});
        r2_r_hi <= r1_d2 * $signed(r1_dx[D-1:L]);

        r3_flg  <= r2_flg;
        r3_l    <= (P'(r2_l_hi) <<< L) + P'(r2_l_lo);
        r3_r    <= (P'(r2_r_hi) <<< L) + P'(r2_r_lo);
    end

endmodule

// File: sv/ppit_back.sv
// Back end: vertex memory, edge sequencer and result register.
// Depends on ppit_pkg and ppit_edge; takes commands from ppit_queue.

module ppit_back #(
    parameter int MAX_VERTICES = ppit_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = ppit_pkg::COORD_BITS_DEF,
    localparam int IDX_W = $clog2(MAX_VERTICES),
    localparam int CNT_W = $clog2(MAX_VERTICES + 1),
    localparam int CMD_W = 1 + IDX_W + 2 * COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ppit_pkg::COUNT_W-1:0] i_vertex_count,
    input  logic                         i_q_valid,
    output logic                         o_q_stall,
    input  logic [CMD_W-1:0]             i_q_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_inside_res
);

    localparam int CW = COORD_BITS;

    ppit_pkg::t_back_state r_state, n_state;

    logic [2*CW-1:0] r_mem [MAX_VERTICES];
    logic [2*CW-1:0] r_rd_data;
    logic [2*CW-1:0] r_prev;
    logic            r_rd_valid;
    logic            r_rd_last;
    logic            r_have_prev;
    logic [CNT_W-1:0] r_rd_cnt;
    logic [CW-1:0]   r_px, r_py;
    logic            r_inside;
    logic            r_out_valid;
    logic            r_out_res;

    logic             q_is_query;
    logic [IDX_W-1:0] q_idx;
    logic [CW-1:0]    q_x, q_y;
    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_last;
    logic             pop, wr_en, start, rd_en, load_out;

    ppit_pkg::t_edge_ctl e_ctl;
    ppit_pkg::t_edge_res e_res;

    assign {q_is_query, q_idx, q_x, q_y} = i_q_data;

    assign n_eff = (int'(i_vertex_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                         : CNT_W'(i_vertex_count);
    assign rd_last = (r_rd_cnt == n_eff);
    assign rd_addr = rd_last ? '0 : r_rd_cnt[IDX_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppit_pkg::ST_IDLE: begin
                if (i_q_valid && (q_is_query == ppit_pkg::FUNC_QUERY)) begin
                    n_state = (n_eff == '0) ? ppit_pkg::ST_DONE : ppit_pkg::ST_RUN;
                end
            end
            ppit_pkg::ST_RUN: begin
                if (rd_last) begin
                    n_state = ppit_pkg::ST_DRAIN;
                end
            end
            ppit_pkg::ST_DRAIN: begin
                if (e_res.valid && e_res.last) begin
                    n_state = ppit_pkg::ST_DONE;
                end
            end
            ppit_pkg::ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ppit_pkg::ST_IDLE;
                end
            end
            default: n_state = ppit_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ppit_pkg::ST_IDLE:  pop      = i_q_valid;
            ppit_pkg::ST_RUN:   rd_en    = 1'b1;
            ppit_pkg::ST_DRAIN: ;
            ppit_pkg::ST_DONE:  load_out = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    assign wr_en     = pop && (q_is_query == ppit_pkg::FUNC_WRITE);
    assign start     = pop && (q_is_query == ppit_pkg::FUNC_QUERY);
    assign o_q_stall = (r_state != ppit_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[q_idx] <= {q_x, q_y};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppit_pkg::ST_IDLE;
            r_rd_valid  <= 1'b0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_en;
            if (start) begin
                r_have_prev <= 1'b0;
            end else if (r_rd_valid) begin
                r_have_prev <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= rd_last;
        if (start) begin
            r_px     <= q_x;
            r_py     <= q_y;
            r_rd_cnt <= '0;
            r_inside <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            end
            if (e_res.valid) begin
                r_inside <= r_inside ^ e_res.hit;
            end
        end
        if (r_rd_valid) begin
            r_prev <= r_rd_data;
        end
        if (load_out) begin
            r_out_res <= r_inside;
        end
    end

    assign e_ctl.valid = r_rd_valid && r_have_prev;
    assign e_ctl.last  = r_rd_last;

    ppit_edge #(
        .COORD_BITS(COORD_BITS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (e_ctl),
        .i_ax    ($signed(r_prev[2*CW-1:CW])),
        .i_ay    ($signed(r_prev[CW-1:0])),
        .i_bx    ($signed(r_rd_data[2*CW-1:CW])),
        .i_by    ($signed(r_rd_data[CW-1:0])),
        .i_px    ($signed(r_px)),
        .i_py    ($signed(r_py)),
        .o_res   (e_res)
    );

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_out_res;

endmodule

// File: sv/polygon_point_inside_test.sv
// Top level of the polygon point-inside test: config register and channel wiring.
// Depends on ppit_pkg, ppit_front, ppit_queue and ppit_back.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | input     | i_in_valid / o_in_stall   | func, vertex_index, coord_x, coord_y
//   out     | output    | o_out_valid / i_out_stall | inside_res
//   cfg     | input     | psel/penable/pwrite/pready| vertex_count at byte address 0
//
// A vertex write is stored as soon as the back end pops it; a query over n vertices holds the
// back end through n + 1 reads (with the wrap to vertex 0), four crossing stages, the flag update
// and the result register.
// A count of zero skips the reads and goes straight to loading the result register.
// Reset is synchronous; vertex_count returns to 4, the vertex memory is not cleared.
// The front end and queue keep taking requests while a query runs or a result waits, until the queue is full.

module polygon_point_inside_test #(
    parameter int MAX_VERTICES = ppit_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = ppit_pkg::COORD_BITS_DEF,
    localparam int IDX_W = $clog2(MAX_VERTICES),
    localparam int CMD_W = 1 + IDX_W + 2 * COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [ppit_pkg::INDEX_W-1:0]  i_vertex_index,
    input  logic [COORD_BITS-1:0]         i_coord_x,
    input  logic [COORD_BITS-1:0]         i_coord_y,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_inside_res,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppit_pkg::APB_AW-1:0]   paddr,
    input  logic [ppit_pkg::APB_DW-1:0]   pwdata,
    output logic [ppit_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    logic [ppit_pkg::COUNT_W-1:0] r_vertex_count;
    logic                         reg_sel;

    logic             push_valid, push_stall;
    logic [CMD_W-1:0] push_data;
    logic             q_valid, q_stall;
    logic [CMD_W-1:0] q_data;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[ppit_pkg::APB_AW-1:2] == ppit_pkg::REG_VERTEX_COUNT);
    assign prdata  = reg_sel ? ppit_pkg::APB_DW'(r_vertex_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= ppit_pkg::COUNT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_vertex_count <= pwdata[ppit_pkg::COUNT_W-1:0];
        end
    end

    ppit_front #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_func         (i_func),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_push_valid   (push_valid),
        .i_push_stall   (push_stall),
        .o_push_data    (push_data)
    );

    ppit_queue #(
        .W(CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push_valid),
        .o_stall (push_stall),
        .i_data  (push_data),
        .o_valid (q_valid),
        .i_stall (q_stall),
        .o_data  (q_data)
    );

    ppit_back #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_count (r_vertex_count),
        .i_q_valid      (q_valid),
        .o_q_stall      (q_stall),
        .i_q_data       (q_data),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_inside_res   (o_inside_res)
    );

endmodule

// File: verif/polygon_point_inside_test_tb.sv
// Testbench for polygon_point_inside_test: random polygons and query points with
// randomized handshake pressure, checked against an in-bench even-odd crossing predictor.
// Depends on ppit_pkg and the polygon_point_inside_test RTL.
`timescale 1ns / 1ps

module polygon_point_inside_test_tb;

    localparam int NV = ppit_pkg::MAX_VERTICES_DEF;
    localparam int CB = ppit_pkg::COORD_BITS_DEF;
    localparam int IW = ppit_pkg::INDEX_W;
    localparam int AW = ppit_pkg::APB_AW;
    localparam int DW = ppit_pkg::APB_DW;
    localparam int CNW = ppit_pkg::COUNT_W;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int DRAIN_WAIT = NV + 32;
    localparam int TARGET_REQS = 1550;
    localparam int LONG_HOLD = 500;
    localparam logic [AW-1:0] ADDR_VCOUNT = AW'({ppit_pkg::REG_VERTEX_COUNT, 2'b00});
    localparam logic [CB-1:0] Q_ONE = CB'(32'h0001_0000);
    localparam logic [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

    typedef struct {
        logic          func;
        logic [IW-1:0] idx;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } t_poly_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_func = ppit_pkg::FUNC_WRITE;
    logic [IW-1:0]        i_vertex_index = '0;
    logic [CB-1:0]        i_coord_x = '0;
    logic [CB-1:0]        i_coord_y = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_inside_res;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AW-1:0]        paddr = '0;
    logic [DW-1:0]        pwdata = '0;
    logic [DW-1:0]        prdata;
    logic                 pready;

    polygon_point_inside_test u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_inside_res   (o_inside_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 i_clk = ~i_clk;

    t_poly_req              pending_req[$];
    logic                   expected_inside[$];
    logic signed [CB-1:0]   vx_store [NV];
    logic signed [CB-1:0]   vy_store [NV];
    logic [CNW-1:0]         vcount_cfg = ppit_pkg::COUNT_RESET;
    logic [CB-1:0]          gen_vx [NV];
    logic [CB-1:0]          gen_vy [NV];
    int                     req_total = 0;
    int                     err_cnt = 0;
    int                     results_seen = 0;
    int                     cycle_cnt = 0;
    int                     gap_left = 0;
    int                     calm_left = 0;
    int                     hold_left = 0;
    int                     stall_run = 0;
    logic                   hold_done = 1'b0;
    logic                   exp_bit;

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    function automatic logic predict_inside(input logic signed [CB-1:0] px,
                                            input logic signed [CB-1:0] py);
        int n;
        int j;
        logic acc;
        logic up;
        logic dn;
        logic signed [CB-1:0] ax, ay, bx, by;
        logic signed [CB+1:0] dxa, dyb, dyq, dxb;
        logic signed [2*CB+3:0] lhs, rhs;
        n = (vcount_cfg > NV) ? NV : int'(vcount_cfg);
        acc = 1'b0;
        for (int i = 0; i < n; i++) begin
            j = (i + 1 < n) ? i + 1 : 0;
            ax = vx_store[i];
            ay = vy_store[i];
            bx = vx_store[j];
            by = vy_store[j];
            up = (ay <= py) && (by > py);
            dn = (ay > py) && (by <= py);
            if (up || dn) begin
                dxa = ax - px;
                dyb = by - ay;
                dyq = ay - py;
                dxb = bx - ax;
                lhs = dxa * dyb;
                rhs = dyq * dxb;
                if (up ? (lhs >= rhs) : (lhs <= rhs))
                    acc = ~acc;
            end
        end
        return acc;
    endfunction

    // driver
    always @(posedge i_clk) begin
        int r;
        t_poly_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (i_func == ppit_pkg::FUNC_WRITE) begin
                    vx_store[i_vertex_index] = i_coord_x;
                    vy_store[i_vertex_index] = i_coord_y;
                end else begin
                    expected_inside = {expected_inside, predict_inside(i_coord_x, i_coord_y)};
                end
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_req.size() > 0) begin
                    req = pending_req.pop_front();
                    i_func <= req.func;
                    i_vertex_index <= req.idx;
                    i_coord_x <= req.x;
                    i_coord_y <= req.y;
                    i_in_valid <= 1'b1;
                    r = $urandom_range(0, 99);
                    if (calm_left > 0) begin
                        calm_left = calm_left - 1;
                        gap_left <= 0;
                    end else if (r < 3) begin
                        calm_left = $urandom_range(30, 80);
                        gap_left <= 0;
                    end else if (r < 55) begin
                        gap_left <= 0;
                    end else if (r < 85) begin
                        gap_left <= $urandom_range(1, 3);
                    end else if (r < 96) begin
                        gap_left <= $urandom_range(4, 10);
                    end else begin
                        gap_left <= $urandom_range(20, 60);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
            stall_run <= 0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen > 40 && pending_req.size() > 12) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                i_out_stall <= 1'b0;
                stall_run <= $urandom_range(0, 15);
            end else if (r < 85) begin
                i_out_stall <= 1'b1;
                stall_run <= $urandom_range(0, 2);
            end else if (r < 96) begin
                i_out_stall <= 1'b1;
                stall_run <= $urandom_range(4, 12);
            end else begin
                i_out_stall <= 1'b1;
                stall_run <= $urandom_range(20, 60);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (expected_inside.size() == 0) begin
                report_mismatch($sformatf("result inside=%0b with none expected",
                                          o_inside_res));
            end else begin
                exp_bit = expected_inside.pop_front();
                if (o_inside_res !== exp_bit)
                    report_mismatch($sformatf("inside got %0b exp %0b",
                                              o_inside_res, exp_bit));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_req(input logic func, input int idx,
                            input logic [CB-1:0] x, input logic [CB-1:0] y);
        t_poly_req req;
        req.func = func;
        req.idx = IW'(idx);
        req.x = x;
        req.y = y;
        if (func == ppit_pkg::FUNC_WRITE) begin
            gen_vx[idx] = x;
            gen_vy[idx] = y;
        end
        pending_req = {pending_req, req};
        req_total++;
    endtask

    task automatic wait_idle();
        while (pending_req.size() != 0 || i_in_valid || expected_inside.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_vcount(input logic [CNW-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_VCOUNT;
        pwdata <= DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        vcount_cfg = val;
    endtask

    function automatic logic [CB-1:0] rand_coord(input int style);
        if (style == 0)
            return CB'((int'($urandom_range(0, 16)) - 8) * 65536);
        else if (style == 1)
            return CB'(int'($urandom_range(0, 2 * (1 << 20))) - (1 << 20));
        return CB'($urandom);
    endfunction

    task automatic gen_polygon(input int m, input int style);
        logic [CB-1:0] y;
        for (int i = 0; i < m; i++) begin
            y = (i > 0 && $urandom_range(0, 99) < 15) ? gen_vy[i-1] : rand_coord(style);
            push_req(ppit_pkg::FUNC_WRITE, i, rand_coord(style), y);
        end
    endtask

    task automatic gen_queries(input int m, input int style, input int q);
        int r;
        int k;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        for (int n = 0; n < q; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                k = (m < NV) ? $urandom_range(m, NV - 1) : $urandom_range(0, NV - 1);
                push_req(ppit_pkg::FUNC_WRITE, k, rand_coord(style), rand_coord(style));
            end else begin
                if (r < 40 && m > 0) begin
                    k = $urandom_range(0, m - 1);
                    y = gen_vy[k];
                    case ($urandom_range(0, 3))
                        0: x = gen_vx[k];
                        1: x = gen_vx[k] + 1;
                        2: x = gen_vx[k] - 1;
                        default: x = rand_coord(style);
                    endcase
                end else if (r < 90) begin
                    x = rand_coord(style);
                    y = rand_coord(style);
                end else begin
                    x = CB'($urandom);
                    y = CB'($urandom);
                end
                push_req(ppit_pkg::FUNC_QUERY, $urandom_range(0, NV - 1), x, y);
            end
        end
    endtask

    initial begin
        int phase;
        int r;
        int cnt;
        int m;
        int style;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // square from -1 to 1 at reset count, then queries inside, on edges, on a corner and outside
        push_req(ppit_pkg::FUNC_WRITE, 0, -Q_ONE, -Q_ONE);
        push_req(ppit_pkg::FUNC_WRITE, 1, Q_ONE, -Q_ONE);
        push_req(ppit_pkg::FUNC_WRITE, 2, Q_ONE, Q_ONE);
        push_req(ppit_pkg::FUNC_WRITE, 3, -Q_ONE, Q_ONE);
        push_req(ppit_pkg::FUNC_QUERY, 0, '0, '0);
        push_req(ppit_pkg::FUNC_QUERY, 0, Q_ONE << 1, '0);
        push_req(ppit_pkg::FUNC_QUERY, 0, -Q_ONE, '0);
        push_req(ppit_pkg::FUNC_QUERY, 0, Q_ONE, '0);
        push_req(ppit_pkg::FUNC_QUERY, 0, '0, -Q_ONE);
        push_req(ppit_pkg::FUNC_QUERY, 0, '0, Q_ONE);
        push_req(ppit_pkg::FUNC_QUERY, 0, -Q_ONE, -Q_ONE);
        push_req(ppit_pkg::FUNC_QUERY, 0, '0, Q_ONE >> 1);
        push_req(ppit_pkg::FUNC_QUERY, 0, -(Q_ONE << 1), '0);
        // coordinate extremes
        push_req(ppit_pkg::FUNC_WRITE, 2, C_MAX, C_MAX);
        push_req(ppit_pkg::FUNC_WRITE, 0, C_MIN, C_MIN);
        push_req(ppit_pkg::FUNC_QUERY, 0, '0, '0);
        push_req(ppit_pkg::FUNC_QUERY, 0, C_MAX, C_MAX);
        push_req(ppit_pkg::FUNC_QUERY, 0, C_MIN, C_MIN);
        push_req(ppit_pkg::FUNC_QUERY, 0, C_MIN, C_MAX);
        push_req(ppit_pkg::FUNC_QUERY, 0, C_MAX, C_MIN);
        wait_idle();
        write_vcount(7'd0);
        push_req(ppit_pkg::FUNC_QUERY, 0, '0, '0);
        wait_idle();
        write_vcount(7'd1);
        push_req(ppit_pkg::FUNC_QUERY, 0, C_MIN, '0);
        wait_idle();
        write_vcount(7'd2);
        push_req(ppit_pkg::FUNC_QUERY, 0, '0, '0);
        push_req(ppit_pkg::FUNC_QUERY, 0, C_MIN, gen_vy[1]);

        phase = 0;
        while (req_total < TARGET_REQS) begin
            wait_idle();
            r = $urandom_range(0, 99);
            if (phase == 0)
                cnt = NV;
            else if (phase == 1)
                cnt = 127;
            else if (r < 3)
                cnt = 0;
            else if (r < 6)
                cnt = 1;
            else if (r < 9)
                cnt = 2;
            else if (r < 11)
                cnt = NV;
            else if (r < 13)
                cnt = $urandom_range(NV + 1, 127);
            else if (r < 85)
                cnt = $urandom_range(3, 12);
            else
                cnt = $urandom_range(13, 40);
            m = (cnt > NV) ? NV : cnt;
            r = $urandom_range(0, 99);
            style = (r < 60) ? 0 : (r < 85) ? 1 : 2;
            write_vcount(CNW'(cnt));
            gen_polygon(m, style);
            gen_queries(m, style, $urandom_range(10, 40));
            phase++;
        end

        while (pending_req.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_inside.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
